// ===== hdl/dta_pkg.sv =====
package dta_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int AGE_W             = 24;
	localparam int SLOT_W            = 4;
	localparam int TOTAL_W           = 5;

	localparam logic [31:0]      ANNOUNCE_MAGIC   = 32'h43524D52;
	localparam logic [7:0]       ANNOUNCE_VERSION = 8'd1;
	localparam logic [AGE_W-1:0] TIMEOUT_RESET    = 24'd5000;

	typedef enum logic {
		CMD_ANNOUNCE = 1'b0,
		CMD_TICK     = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_BAD_MAGIC   = 3'd0,
		STAT_BAD_VERSION = 3'd1,
		STAT_UPDATED     = 3'd2,
		STAT_INSERTED    = 3'd3,
		STAT_FULL        = 3'd4,
		STAT_TICK        = 3'd5
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] magic;
		logic [7:0]  version;
		logic [31:0] sender_ip;
		logic [15:0] game_port;
		logic [7:0]  current_players;
		logic [7:0]  max_players;
		logic [7:0]  game_mode;
		logic [15:0] elapsed_ms;
	} in_t;

	typedef struct packed {
		status_t              status;
		logic [SLOT_W-1:0]    slot;
		logic [TOTAL_W-1:0]   entry_total;
		logic [TOTAL_W-1:0]   expired_count;
	} out_t;

	typedef struct packed {
		logic [31:0]      ip;
		logic [15:0]      port;
		logic [7:0]       players_now;
		logic [7:0]       players_cap;
		logic [7:0]       mode;
		logic [AGE_W-1:0] age;
	} entry_t;

	typedef struct packed {
		logic finish;
		out_t res;
	} ctrl_res_t;

endpackage

// ===== hdl/discovery_table_with_aging_core.sv =====
// channel   | signals                    | handshake
// ----------+----------------------------+-------------------------------------
// request   | start, busy, req           | taken at a clock edge with start & !busy
// result    | done, result               | done high for one cycle, always taken
// config    | cfg_we, cfg_wdata          | timeout_ms written at an edge with cfg_we
//
// an announcement with bad magic or bad version answers on the next cycle and leaves busy low
// other requests scan the entry memory one entry per cycle through its single read port,
// so busy holds for the whole scan and done rises as busy falls
// an update stops the scan at the matching entry
// reset clears the valid bits and the count at once, no clearing pass is needed
// the result register lets a new request be taken while done is still high
module discovery_table_with_aging_core
	import dta_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_t              req,
	input  logic             cfg_we,
	input  logic [AGE_W-1:0] cfg_wdata,
	output logic             done,
	output out_t             result
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// timeout register
	logic [AGE_W-1:0] timeout_q;

	// entry memory ports
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;

	ctrl_res_t ctrl_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// host entries: key, player counts, mode and age
	dta_entry_ram #(
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// scan sequencer, valid bits and valid count
	dta_scan_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req),
		.timeout_ms (timeout_q),
		.busy       (busy),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.ctrl_res   (ctrl_res)
	);

	// result register, one strobe per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctrl_res.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_res.finish) begin
			result <= ctrl_res.res;
		end
	end

	// a tick always scans the table
	a_tick_scans: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.cmd == CMD_TICK) |=> busy)
		else $error("tick request did not start a scan");

	// a valid announcement scans, so no result on the next cycle
	a_scan_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.cmd == CMD_ANNOUNCE) && (req.magic == ANNOUNCE_MAGIC) &&
		(req.version == ANNOUNCE_VERSION) |=> !done)
		else $error("announcement answered without a scan");

	// only ticks remove entries
	a_expired_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != STAT_TICK) |-> (result.expired_count == '0))
		else $error("expired count on an announcement");

	// an insert leaves at least one entry
	a_insert_total: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == STAT_INSERTED) && (TABLE_ENTRIES < 32) |->
		(result.entry_total != '0))
		else $error("insert with empty table count");

endmodule

// ===== hdl/dta_entry_ram.sv =====
module dta_entry_ram
	import dta_pkg::*;
#(
	parameter int DEPTH = TABLE_ENTRIES_DEF
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  entry_t                                wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output entry_t                                rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/dta_scan_ctrl.sv =====
module dta_scan_ctrl
	import dta_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  in_t              req,
	input  logic [AGE_W-1:0] timeout_ms,
	output logic             busy,
	output logic             mem_we,
	output logic [IDX_W-1:0] mem_waddr,
	output entry_t           mem_wdata,
	output logic [IDX_W-1:0] mem_raddr,
	input  entry_t           mem_rdata,
	output ctrl_res_t        ctrl_res
);

	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	state_t                   state_q, state_d;
	in_t                      req_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     act_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]         total_q, total_d;
	logic [CNT_W-1:0]         exp_q, exp_d;
	logic                     have_free_q, have_free_d;
	logic [IDX_W-1:0]         free_q, free_d;

	logic             accept;
	logic             early_drop;
	logic             rd_issue;
	logic             cur_valid;
	logic             key_hit;
	logic             last_s1;
	logic [AGE_W:0]   age_sum;
	logic [AGE_W-1:0] age_new;
	logic             valid_clr;
	logic             valid_set;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign early_drop = (req.cmd == CMD_ANNOUNCE) &&
		((req.magic != ANNOUNCE_MAGIC) || (req.version != ANNOUNCE_VERSION));
	assign rd_issue   = (state_q == S_SCAN) && (cnt_q < CNT_END);
	assign mem_raddr  = cnt_q[IDX_W-1:0];
	assign cur_valid  = valid_q[idx_s1];
	assign key_hit    = (mem_rdata.ip == req_q.sender_ip) && (mem_rdata.port == req_q.game_port);
	assign last_s1    = (idx_s1 == IDX_LAST);
	assign age_sum    = {1'b0, mem_rdata.age} + (AGE_W + 1)'(req_q.elapsed_ms);
	assign age_new    = age_sum[AGE_W] ? {AGE_W{1'b1}} : age_sum[AGE_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && !early_drop) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (ctrl_res.finish) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// datapath and result
	always_comb begin
		mem_we          = 1'b0;
		mem_waddr       = idx_s1;
		mem_wdata       = mem_rdata;
		valid_clr       = 1'b0;
		valid_set       = 1'b0;
		total_d         = total_q;
		exp_d           = exp_q;
		have_free_d     = have_free_q;
		free_d          = free_q;
		ctrl_res.finish = 1'b0;
		ctrl_res.res    = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && early_drop) begin
					ctrl_res.finish = 1'b1;
					ctrl_res.res.status = (req.magic != ANNOUNCE_MAGIC) ?
						STAT_BAD_MAGIC : STAT_BAD_VERSION;
					ctrl_res.res.entry_total = TOTAL_W'(total_q);
				end
			end
			S_SCAN: begin
				if (act_s1) begin
					if (req_q.cmd == CMD_TICK) begin
						if (cur_valid) begin
							mem_we        = 1'b1;
							mem_wdata.age = age_new;
							if (age_new > timeout_ms) begin
								valid_clr = 1'b1;
								total_d   = total_q - CNT_ONE;
								exp_d     = exp_q + CNT_ONE;
							end
						end
						if (last_s1) begin
							ctrl_res.finish              = 1'b1;
							ctrl_res.res.status          = STAT_TICK;
							ctrl_res.res.entry_total     = TOTAL_W'(total_d);
							ctrl_res.res.expired_count   = TOTAL_W'(exp_d);
						end
					end else begin
						if (cur_valid && key_hit) begin
							// refresh matching host
							mem_we                = 1'b1;
							mem_wdata.players_now = req_q.current_players;
							mem_wdata.age         = '0;
							ctrl_res.finish          = 1'b1;
							ctrl_res.res.status      = STAT_UPDATED;
							ctrl_res.res.slot        = SLOT_W'(idx_s1);
							ctrl_res.res.entry_total = TOTAL_W'(total_q);
						end else begin
							if (!cur_valid && !have_free_q) begin
								have_free_d = 1'b1;
								free_d      = idx_s1;
							end
							if (last_s1) begin
								ctrl_res.finish = 1'b1;
								if (have_free_d) begin
									mem_we                = 1'b1;
									mem_waddr             = free_d;
									mem_wdata.ip          = req_q.sender_ip;
									mem_wdata.port        = req_q.game_port;
									mem_wdata.players_now = req_q.current_players;
									mem_wdata.players_cap = req_q.max_players;
									mem_wdata.mode        = req_q.game_mode;
									mem_wdata.age         = '0;
									valid_set             = 1'b1;
									total_d               = total_q + CNT_ONE;
									ctrl_res.res.status   = STAT_INSERTED;
									ctrl_res.res.slot     = SLOT_W'(free_d);
								end else begin
									ctrl_res.res.status = STAT_FULL;
								end
								ctrl_res.res.entry_total = TOTAL_W'(total_d);
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			act_s1      <= 1'b0;
			valid_q     <= '0;
			total_q     <= '0;
			exp_q       <= '0;
			have_free_q <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			if (valid_clr) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (valid_set) begin
				valid_q[free_d] <= 1'b1;
			end
			if (accept) begin
				cnt_q       <= '0;
				act_s1      <= 1'b0;
				exp_q       <= '0;
				have_free_q <= 1'b0;
			end else begin
				if (rd_issue) begin
					cnt_q <= cnt_q + CNT_ONE;
				end
				act_s1      <= rd_issue && !ctrl_res.finish;
				exp_q       <= exp_d;
				have_free_q <= have_free_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		idx_s1 <= cnt_q[IDX_W-1:0];
		free_q <= free_d;
	end

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dta_pkg::*;

	localparam int ROWS        = TABLE_ENTRIES_DEF;
	localparam int KEY_POOL    = 24;       // more keys than rows so the table fills up
	localparam int RUN_LIMIT   = 600000;   // watchdog, many times the slowest legal run
	localparam int DRAIN_GUARD = TABLE_ENTRIES_DEF + 4;
	localparam int PRINT_CAP   = 100;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	in_t              req;
	logic             cfg_we;
	logic [AGE_W-1:0] cfg_wdata;
	logic             done;
	out_t             result;

	// shadow copy of the host table, only what the answers depend on
	bit               row_valid [ROWS];
	logic [31:0]      row_ip    [ROWS];
	logic [15:0]      row_port  [ROWS];
	logic [AGE_W-1:0] row_age   [ROWS];
	int               row_count   = 0;
	logic [AGE_W-1:0] timeout_now = TIMEOUT_RESET;

	// answers owed by the block, oldest first
	out_t answers_due [$];

	logic [31:0] pool_ip   [KEY_POOL];
	logic [15:0] pool_port [KEY_POOL];

	int error_count  = 0;
	int cycle_count  = 0;
	bit quiet_sender = 1'b0;

	discovery_table_with_aging_core #(
		.TABLE_ENTRIES(ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.result(result)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d answers outstanding",
				cycle_count, answers_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// next answer for one accepted request, updates the shadow table
	function automatic out_t predict_answer(in_t item);
		out_t           ans;
		int             hit;
		int             free_row;
		int             expired;
		logic [AGE_W:0] sum;
		ans      = '0;
		hit      = -1;
		free_row = -1;
		expired  = 0;
		if (item.cmd == CMD_TICK) begin
			// age every live row, saturate, then drop the stale ones
			for (int i = 0; i < ROWS; i++) begin
				if (row_valid[i]) begin
					sum = {1'b0, row_age[i]} + (AGE_W + 1)'(item.elapsed_ms);
					row_age[i] = sum[AGE_W] ? {AGE_W{1'b1}} : sum[AGE_W-1:0];
					if (row_age[i] > timeout_now) begin
						row_valid[i] = 1'b0;
						row_count--;
						expired++;
					end
				end
			end
			ans.status        = STAT_TICK;
			ans.expired_count = TOTAL_W'(expired);
		end else if (item.magic != ANNOUNCE_MAGIC) begin
			ans.status = STAT_BAD_MAGIC;
		end else if (item.version != ANNOUNCE_VERSION) begin
			ans.status = STAT_BAD_VERSION;
		end else begin
			// first matching live row wins, else lowest free row seen before it
			for (int i = 0; i < ROWS; i++) begin
				if (row_valid[i]) begin
					if (hit < 0 && row_ip[i] == item.sender_ip && row_port[i] == item.game_port)
						hit = i;
				end else if (free_row < 0 && hit < 0) begin
					free_row = i;
				end
			end
			if (hit >= 0) begin
				row_age[hit] = '0;
				ans.status   = STAT_UPDATED;
				ans.slot     = SLOT_W'(hit);
			end else if (free_row < 0) begin
				ans.status = STAT_FULL;
			end else begin
				row_valid[free_row] = 1'b1;
				row_ip[free_row]    = item.sender_ip;
				row_port[free_row]  = item.game_port;
				row_age[free_row]   = '0;
				row_count++;
				ans.status = STAT_INSERTED;
				ans.slot   = SLOT_W'(free_row);
			end
		end
		ans.entry_total = TOTAL_W'(row_count);
		return ans;
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
	endtask

	// results sampled mid-cycle, done lasts exactly one cycle
	always @(negedge clk) begin
		out_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (answers_due.size() == 0) begin
				report_mismatch("result with no request waiting");
			end else begin
				want = answers_due.pop_front();
				check_field("status", 32'(result.status), 32'(want.status));
				check_field("slot", 32'(result.slot), 32'(want.slot));
				check_field("entry_total", 32'(result.entry_total), 32'(want.entry_total));
				check_field("expired_count", 32'(result.expired_count),
					32'(want.expired_count));
			end
		end
	end

	// well-formed announcement, tick field filled with junk
	function automatic in_t make_announce(logic [31:0] ip, logic [15:0] port,
		logic [7:0] now, logic [7:0] cap, logic [7:0] mode);
		in_t item;
		item.cmd             = CMD_ANNOUNCE;
		item.magic           = ANNOUNCE_MAGIC;
		item.version         = ANNOUNCE_VERSION;
		item.sender_ip       = ip;
		item.game_port       = port;
		item.current_players = now;
		item.max_players     = cap;
		item.game_mode       = mode;
		item.elapsed_ms      = 16'($urandom);
		return item;
	endfunction

	// tick, packet fields are junk and sometimes look like a good header
	function automatic in_t make_tick(logic [15:0] elapsed);
		in_t item;
		item = make_announce($urandom, 16'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
		item.cmd        = CMD_TICK;
		item.elapsed_ms = elapsed;
		if ($urandom_range(3) != 0) begin
			item.magic   = $urandom;
			item.version = 8'($urandom);
		end
		return item;
	endfunction

	function automatic in_t random_request(int tick_pct, int elapsed_hi);
		in_t item;
		int  roll;
		int  pick;
		pick = $urandom_range(KEY_POOL - 1);
		if ($urandom_range(99) < tick_pct) begin
			if ($urandom_range(19) == 0)
				item = make_tick(16'hFFFF);
			else
				item = make_tick(16'($urandom_range(elapsed_hi)));
		end else begin
			item = make_announce(pool_ip[pick], pool_port[pick], 8'($urandom),
				8'($urandom), 8'($urandom));
			roll = $urandom_range(99);
			// mostly good announcements, some noise and broken headers
			if (roll < 5) begin
				item.magic = $urandom;
			end else if (roll < 10) begin
				item.version = 8'($urandom);
				if (item.version == ANNOUNCE_VERSION)
					item.version = 8'd0;
			end else if (roll < 15) begin
				item.sender_ip = $urandom;
				item.game_port = 16'($urandom);
			end
		end
		return item;
	endfunction

	// one request, random idle before it, waits for the block to take it
	task automatic send_request(in_t item);
		bit taken;
		taken = 1'b0;
		if (!quiet_sender) begin
			while ($urandom_range(99) < 10) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		req   <= item;
		// busy is stable from mid-cycle up to the next edge
		while (!taken) begin
			@(negedge clk);
			taken = (busy === 1'b0);
			@(posedge clk);
		end
		answers_due.push_back(predict_answer(item));
	endtask

	task automatic wait_results_drained();
		start <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// timeout only changes while the block is idle
	task automatic write_timeout(logic [AGE_W-1:0] value);
		wait_results_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we      <= 1'b0;
		timeout_now  = value;
	endtask

	task automatic run_traffic(int count, int tick_pct, int elapsed_hi);
		repeat (count)
			send_request(random_request(tick_pct, elapsed_hi));
	endtask

	task automatic test_bad_packets();
		in_t item;
		item = make_announce(32'h0A00_0001, 16'd1000, 8'd1, 8'd8, 8'd0);
		item.magic = '0;
		send_request(item);
		item.magic = '1;
		send_request(item);
		item.magic   = ANNOUNCE_MAGIC;
		item.version = 8'd0;
		send_request(item);
		item.version = 8'hFF;
		send_request(item);
		// bad magic takes precedence over bad version
		item.magic   = ANNOUNCE_MAGIC ^ 32'h8000_0000;
		item.version = 8'd2;
		send_request(item);
	endtask

	task automatic test_insert_update();
		in_t low_host;
		in_t high_host;
		low_host  = make_announce('0, '0, '0, '0, '0);
		high_host = make_announce('1, '1, '1, '1, '1);
		send_request(low_host);
		send_request(high_host);
		// refresh of an existing key
		low_host.current_players = '1;
		send_request(low_host);
		// same address, other port is a new key
		high_host.game_port = 16'h7FFF;
		send_request(high_host);
	endtask

	task automatic test_table_full();
		for (int k = 0; k < ROWS - 3; k++)
			send_request(make_announce(32'hC0A8_0000 + k, 16'd4000, 8'(k), 8'd16, 8'(k)));
		// new key with no free row
		send_request(make_announce(32'hC0A8_00FF, 16'd4000, 8'd3, 8'd16, 8'd2));
		// update still works on a full table
		send_request(make_announce('1, '1, 8'd7, 8'd0, 8'd0));
	endtask

	task automatic test_aging();
		write_timeout(24'd1000);
		send_request(make_tick(16'd0));
		send_request(make_tick(16'd999));
		send_request(make_tick(16'hFFFF));
	endtask

	task automatic test_timeout_zero();
		write_timeout('0);
		send_request(make_announce(32'h0A0A_0A0A, 16'd27015, 8'd2, 8'd4, 8'd1));
		// zero age survives, any nonzero age goes
		send_request(make_tick(16'd0));
		send_request(make_tick(16'd1));
	endtask

	task automatic test_age_saturation();
		in_t noise;
		write_timeout('1);
		send_request(make_announce(32'hAC10_0001, 16'd1, 8'd1, 8'd2, 8'd3));
		send_request(make_announce(32'hAC10_0002, 16'd2, 8'd1, 8'd2, 8'd3));
		// enough full-size ticks to pin the ages at the top
		repeat (258) begin
			if ($urandom_range(9) == 0) begin
				noise = make_announce($urandom, 16'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
				noise.magic = $urandom;
				send_request(noise);
			end
			send_request(make_tick(16'hFFFF));
		end
		// pinned ages now sit one above the timeout
		write_timeout(24'hFFFFFE);
		send_request(make_tick(16'd0));
	endtask

	task automatic test_random_traffic();
		for (int k = 0; k < KEY_POOL; k++) begin
			pool_ip[k]   = $urandom;
			pool_port[k] = 16'($urandom);
		end
		write_timeout(TIMEOUT_RESET);
		run_traffic(400, 15, 1500);
		write_timeout(24'd1);
		run_traffic(300, 20, 3);
		// back-to-back stretch, sender never idles
		quiet_sender = 1'b1;
		write_timeout(AGE_W'($urandom_range(1000, 200000)));
		run_traffic(350, 15, 65535);
		quiet_sender = 1'b0;
		write_timeout('0);
		run_traffic(300, 25, 2);
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default timeout is in force for the first tests
		test_bad_packets();
		test_insert_update();
		test_table_full();
		test_aging();
		test_timeout_zero();
		test_age_saturation();
		test_random_traffic();

		wait_results_drained();
		repeat (DRAIN_GUARD) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/dta_pkg.sv
hdl/dta_entry_ram.sv
hdl/dta_scan_ctrl.sv
hdl/discovery_table_with_aging_core.sv
tb/tb.sv
